// ===== hw/rtl/mpu_pkg.sv =====
// Package: types and constants shared by the matrix power unit.
`timescale 1ns / 1ps
package mpu_pkg;
  localparam int DIM   = 4;
  localparam int WIDTH = 32;
  localparam int NEL   = DIM * DIM;
  localparam int IW    = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int EW    = (NEL > 1) ? $clog2(NEL) : 1;
  localparam int EXP_W = 63;

  typedef enum logic [2:0] {
    OP_LOAD_A = 3'd0,
    OP_LOAD_B = 3'd1,
    OP_ADD    = 3'd2,
    OP_SUB    = 3'd3,
    OP_MUL    = 3'd4,
    OP_POW    = 3'd5
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_CHECK,
    S_MUL,
    S_DRAIN,
    S_COPY,
    S_SHIFT,
    S_EMIT
  } state_e;

  typedef enum logic [1:0] {
    SRC_ADD,
    SRC_SUB,
    SRC_SCR,
    SRC_ACC
  } src_e;

  typedef enum logic [1:0] {
    MOP_AB,
    MOP_ACC,
    MOP_SQR
  } mop_e;

  typedef struct packed {
    logic [2:0]       opcode;
    logic [1:0]       row;
    logic [1:0]       col;
    logic [31:0]      value;
    logic [EXP_W-1:0] exponent;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  out_row;
    logic [1:0]  out_col;
    logic [31:0] out_value;
    logic        last;
  } out_word_t;
endpackage

// ===== hw/rtl/matrix_power_unit.sv =====
// Top level: matrix add/subtract/multiply/power coprocessor.
`timescale 1ns / 1ps
// Usage:
//  Input channel (in_valid_i, in_stall_o, in_word_i): load words write one
//  element of A or B and leave the input ready for the next word. Compute
//  words (add, sub, mul, pow) hold in_stall_o high until the last result
//  word has been loaded into the output register.
//  Output channel (out_valid_o, out_stall_i, out_word_o): DIM*DIM words in
//  row-major order, last set on the final one.
//  Sequence per compute word:
//    add/sub: emit directly from A and B
//    mul:     multiply (one shared 32x32 multiplier, one MAC per cycle),
//             then drain and emit
//    pow:     init, then per exponent bit a check and a shift step and up
//             to two products, each followed by a copy, then emit; the
//             exponent is up to 63 bits wide.
//  Products in mul and pow run through the shared multiply-accumulate unit.
//  Reset clears A and B to zero and returns to idle with no output pending.
//  A stalled output word holds; emission pauses until it is taken.
module matrix_power_unit
  import mpu_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  state_e state_q, state_d;
  src_e   src_q;
  mop_e   mop_q;
  logic [WIDTH-1:0] a_q [NEL];
  logic [WIDTH-1:0] b_q [NEL];
  logic [WIDTH-1:0] base_q [NEL];
  logic [WIDTH-1:0] base2_q [NEL];
  logic [WIDTH-1:0] acc_m_q [NEL];
  logic [WIDTH-1:0] scr_q [NEL];
  logic [EXP_W-1:0] exp_q;
  logic [EW-1:0]    idx_q;
  logic [3*IW-1:0]  cnt_q;
  logic [WIDTH-1:0] prod_q, sum_q;
  logic             pv_q, pk0_q, plast_q;
  logic [EW-1:0]    paddr_q;
  logic             out_valid_q;
  out_word_t        out_q;

  logic             accept, out_free, idx_end, cnt_end;
  logic [IW-1:0]    r_i, c_i, k_i;
  logic [EW-1:0]    xa, ya;
  logic [WIDTH-1:0] xv, yv, mac_sum, emit_val;
  logic [2*WIDTH-1:0] prod_full;
  logic [EXP_W-1:0] exp_sh;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign idx_end  = (idx_q == EW'(NEL - 1));
  assign cnt_end  = (cnt_q == {(3*IW){1'b1}});
  assign {r_i, c_i, k_i} = cnt_q;
  assign xa = EW'({r_i, k_i});
  assign ya = EW'({k_i, c_i});
  assign exp_sh = exp_q >> 1;

  always_comb begin
    case (mop_q)
      MOP_AB:  begin xv = a_q[xa];     yv = b_q[ya];     end
      MOP_ACC: begin xv = acc_m_q[xa]; yv = base_q[ya];  end
      default: begin xv = base_q[xa];  yv = base2_q[ya]; end
    endcase
  end
  assign prod_full = xv * yv;
  assign mac_sum = (pk0_q ? '0 : sum_q) + prod_q;

  always_comb begin
    case (src_q)
      SRC_ADD: emit_val = a_q[idx_q] + b_q[idx_q];
      SRC_SUB: emit_val = b_q[idx_q] - a_q[idx_q];
      SRC_SCR: emit_val = scr_q[idx_q];
      default: emit_val = acc_m_q[idx_q];
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_word_i.opcode)
            OP_ADD, OP_SUB: state_d = S_EMIT;
            OP_MUL:         state_d = S_MUL;
            OP_POW:         state_d = S_INIT;
            default:        state_d = S_IDLE;
          endcase
        end
      end
      S_INIT:  if (idx_end) state_d = S_CHECK;
      S_CHECK: begin
        if (exp_q == '0)  state_d = S_EMIT;
        else if (exp_q[0]) state_d = S_MUL;
        else              state_d = S_SHIFT;
      end
      S_MUL:   if (cnt_end) state_d = S_DRAIN;
      S_DRAIN: state_d = (mop_q == MOP_AB) ? S_EMIT : S_COPY;
      S_COPY: begin
        if (idx_end) state_d = (mop_q == MOP_ACC) ? S_SHIFT : S_CHECK;
      end
      S_SHIFT: state_d = (exp_sh != '0) ? S_MUL : S_CHECK;
      S_EMIT:  if (out_free && idx_end) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_stall_o  = (state_q != S_IDLE);
    out_valid_o = out_valid_q;
    out_word_o  = out_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      exp_q       <= '0;
      pv_q        <= 1'b0;
      for (int i = 0; i < NEL; i++) begin
        a_q[i] <= '0;
        b_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      pv_q    <= (state_q == S_MUL);
      out_valid_q <= (state_q == S_EMIT && out_free) || (out_valid_q && out_stall_i);
      case (state_q)
        S_IDLE: begin
          if (accept && in_word_i.opcode == OP_POW) exp_q <= in_word_i.exponent;
          if (accept && int'(in_word_i.row) < DIM && int'(in_word_i.col) < DIM) begin
            if (in_word_i.opcode == OP_LOAD_A)
              a_q[EW'({in_word_i.row[IW-1:0], in_word_i.col[IW-1:0]})]
                <= WIDTH'(in_word_i.value);
            if (in_word_i.opcode == OP_LOAD_B)
              b_q[EW'({in_word_i.row[IW-1:0], in_word_i.col[IW-1:0]})]
                <= WIDTH'(in_word_i.value);
          end
        end
        S_SHIFT: exp_q <= exp_sh;
        default: ;
      endcase
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk_i) begin
    prod_q  <= prod_full[WIDTH-1:0];
    pk0_q   <= (k_i == '0);
    plast_q <= (k_i == {IW{1'b1}});
    paddr_q <= EW'({r_i, c_i});
    if (pv_q) begin
      sum_q <= mac_sum;
      if (plast_q) scr_q[paddr_q] <= mac_sum;
    end
    case (state_q)
      S_IDLE: begin
        idx_q <= '0;
        cnt_q <= '0;
        mop_q <= MOP_AB;
        case (in_word_i.opcode)
          OP_ADD:  src_q <= SRC_ADD;
          OP_SUB:  src_q <= SRC_SUB;
          OP_MUL:  src_q <= SRC_SCR;
          default: src_q <= SRC_ACC;
        endcase
      end
      S_INIT: begin
        base_q[idx_q]  <= a_q[idx_q];
        base2_q[idx_q] <= a_q[idx_q];
        acc_m_q[idx_q] <= (idx_q[EW-1:IW] == idx_q[IW-1:0]) ? WIDTH'(1) : '0;
        idx_q <= idx_q + 1'b1;
      end
      S_CHECK: begin
        idx_q <= '0;
        cnt_q <= '0;
        mop_q <= MOP_ACC;
      end
      S_MUL:   cnt_q <= cnt_q + 1'b1;
      S_DRAIN: idx_q <= '0;
      S_COPY: begin
        if (mop_q == MOP_ACC) acc_m_q[idx_q] <= scr_q[idx_q];
        else begin
          base_q[idx_q]  <= scr_q[idx_q];
          base2_q[idx_q] <= scr_q[idx_q];
        end
        idx_q <= idx_q + 1'b1;
      end
      S_SHIFT: begin
        cnt_q <= '0;
        mop_q <= MOP_SQR;
      end
      S_EMIT: begin
        if (out_free) begin
          out_q.out_row   <= 2'(idx_q[EW-1:IW]);
          out_q.out_col   <= 2'(idx_q[IW-1:0]);
          out_q.out_value <= 32'(emit_val);
          out_q.last      <= idx_end;
          idx_q <= idx_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/mpu_checker.sv =====
// Port-level checker for the matrix power unit, bound to the top level.
`timescale 1ns / 1ps
module mpu_checker
  import mpu_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_word_t  in_word_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_word_t out_word_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o) else $error("output word dropped");
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_word_o)) else $error("stalled word changed");
  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o &&
    (in_word_i.opcode == OP_LOAD_A || in_word_i.opcode == OP_LOAD_B)
    |=> !in_stall_o) else $error("load did not return to ready");
  a_compute_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o &&
    (in_word_i.opcode == OP_ADD || in_word_i.opcode == OP_SUB ||
     in_word_i.opcode == OP_MUL || in_word_i.opcode == OP_POW)
    |=> in_stall_o) else $error("compute word did not busy the unit");
endmodule

bind matrix_power_unit mpu_checker u_mpu_checker (.*);
